// ===== sv/pcet_pkg.sv =====
// Shared codes for the per-rule condition edge tracker.
// Status, operation and outcome encodings; no dependencies.
package pcet_pkg;

	typedef logic [3:0] status_t;
	typedef logic [1:0] outcome_t;

	// Operation codes
	localparam logic OP_EVAL    = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Condition outcome codes; anything above OUT_FALSE is an evaluator error
	localparam outcome_t OUT_TRUE  = 2'd0;
	localparam outcome_t OUT_FALSE = 2'd1;

	// Status codes
	localparam status_t ST_OK         = 4'd0;
	localparam status_t ST_BAD_ID     = 4'd1;
	localparam status_t ST_BAD_REQ    = 4'd2;
	localparam status_t ST_NOT_FOUND  = 4'd3;
	localparam status_t ST_INVALID    = 4'd4;
	localparam status_t ST_DISABLED   = 4'd5;
	localparam status_t ST_FULL       = 4'd6;
	localparam status_t ST_EVAL_FAIL  = 4'd7;
	localparam status_t ST_QUEUE_FULL = 4'd8;

	// Width of the slot count port and its saturation value
	localparam int USED_W   = 5;
	localparam int USED_MAX = 31;

endpackage

// ===== sv/per_rule_condition_edge_tracker.sv =====
// Per-rule condition edge tracker: a request that fails an early check or releases id zero
// goes straight to the result, while any other request first scans the slot keys.
// A key scan reads one slot key per cycle from the key memory through a single shared
// comparator; the block takes one transaction at a time, stalling input until its result
// is handed over. The result register lets the next transaction start while a result
// waits. Reset clears all slot valid, primed and outcome bits at once.
module per_rule_condition_edge_tracker #(
	parameter int SLOTS   = 16,
	parameter int ID_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    op,
	input  logic [15:0]             rule_id,
	input  logic                    request_ok,
	input  logic                    rule_found,
	input  logic                    rule_valid,
	input  logic                    rule_enabled,
	input  pcet_pkg::outcome_t      eval_outcome,
	input  logic                    queue_accepts,
	input  logic [31:0]             now_ms,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output pcet_pkg::status_t       status,
	output logic                    trigger_valid,
	output logic                    trigger_rising,
	output logic [15:0]             trigger_rule_id,
	output logic [31:0]             trigger_time_ms,
	output logic [pcet_pkg::USED_W-1:0] slots_used
);
	import pcet_pkg::*;

	localparam int KEY_W = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]       state_q;

	// Slot table: flags in flip-flops, keys in memory
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] primed_q;
	logic [SLOTS-1:0] last_q;
	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [CNT_W-1:0] used_q;

	// Captured transaction
	logic             op_q;
	logic [KEY_W-1:0] id_q;
	logic             enabled_q;
	outcome_t         outcome_q;
	logic             queue_q;
	logic [31:0]      now_q;

	// Scan control
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             cmp_live_q;
	logic [KEY_W-1:0] key_rd_q;
	logic             hit_q;
	logic [IDX_W-1:0] slot_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_q;

	// Pending result
	status_t          res_status_q;
	logic             res_trig_q;
	logic             res_rising_q;

	// Output register
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_trig_q;
	logic             out_rising_q;
	logic [15:0]      out_id_q;
	logic [31:0]      out_time_q;
	logic [USED_W-1:0] out_used_q;

	logic [KEY_W-1:0] in_id;
	logic             accept;
	logic             early_done;
	status_t          early_status;
	logic             cmp_hit;
	logic             out_free;

	// Apply-step decisions
	logic [IDX_W-1:0] ap_sel;
	logic             ap_have;
	logic             ap_claim;
	logic             ap_release;
	logic             ap_primed_we;
	logic             ap_primed_val;
	logic             ap_last_we;
	logic             ap_last_val;
	logic             ap_trig;
	logic             ap_rising;
	status_t          ap_status;
	logic             cur_primed;
	logic             cur_last;
	logic             is_true;

	assign in_id    = rule_id[KEY_W-1:0];
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Run the checks that need no slot lookup
	always_comb begin
		early_done   = 1'b0;
		early_status = ST_OK;
		if (in_id == '0) begin
			early_done   = 1'b1;
			early_status = (op == OP_RELEASE) ? ST_OK : ST_BAD_ID;
		end else if (op == OP_EVAL) begin
			if (!request_ok) begin
				early_done   = 1'b1;
				early_status = ST_BAD_REQ;
			end else if (!rule_found) begin
				early_done   = 1'b1;
				early_status = ST_NOT_FOUND;
			end else if (!rule_valid) begin
				early_done   = 1'b1;
				early_status = ST_INVALID;
			end
		end
	end

	// Shared key comparator
	assign cmp_hit = cmp_live_q && valid_q[cmp_idx_q] && (key_rd_q == id_q);

	// Decide the slot update and result once the scan is over
	always_comb begin
		ap_sel        = hit_q ? slot_q : free_q;
		ap_have       = hit_q;
		ap_claim      = 1'b0;
		ap_release    = 1'b0;
		ap_primed_we  = 1'b0;
		ap_primed_val = 1'b0;
		ap_last_we    = 1'b0;
		ap_last_val   = 1'b0;
		ap_trig       = 1'b0;
		ap_rising     = 1'b0;
		ap_status     = ST_OK;
		is_true       = (outcome_q == OUT_TRUE);
		cur_primed    = hit_q ? primed_q[slot_q] : 1'b0;
		cur_last      = hit_q ? last_q[slot_q] : 1'b0;
		if (op_q == OP_RELEASE) begin
			if (hit_q) begin
				ap_release   = 1'b1;
				ap_primed_we = 1'b1;
				ap_last_we   = 1'b1;
			end
		end else if (!enabled_q) begin
			ap_status = ST_DISABLED;
			if (hit_q) begin
				ap_primed_we = 1'b1;
				ap_last_we   = 1'b1;
			end
		end else begin
			if (!hit_q) begin
				if (free_found_q) begin
					ap_claim     = 1'b1;
					ap_have      = 1'b1;
					ap_primed_we = 1'b1;
					ap_last_we   = 1'b1;
				end else begin
					ap_status = ST_FULL;
				end
			end
			if (ap_have) begin
				if (outcome_q != OUT_TRUE && outcome_q != OUT_FALSE) begin
					ap_status = ST_EVAL_FAIL;
				end else if (!cur_primed) begin
					ap_primed_we  = 1'b1;
					ap_primed_val = 1'b1;
					ap_last_we    = 1'b1;
					ap_last_val   = is_true;
				end else if (cur_last != is_true) begin
					if (!queue_q) begin
						ap_status = ST_QUEUE_FULL;
					end else begin
						ap_trig     = 1'b1;
						ap_rising   = is_true;
						ap_last_we  = 1'b1;
						ap_last_val = is_true;
					end
				end
			end
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op;
			id_q      <= in_id;
			enabled_q <= rule_enabled;
			outcome_q <= eval_outcome;
			queue_q   <= queue_accepts;
			now_q     <= now_ms;
		end
	end

	// Key memory: one read port for the scan, one write port for claims
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			key_rd_q <= key_mem[rd_idx_q];
		end
		if (state_q == S_APPLY && ap_claim) begin
			key_mem[ap_sel] <= id_q;
		end
	end

	// Sequencer, slot flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			primed_q     <= '0;
			last_q       <= '0;
			used_q       <= '0;
			rd_idx_q     <= '0;
			cmp_idx_q    <= '0;
			cmp_live_q   <= 1'b0;
			hit_q        <= 1'b0;
			slot_q       <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			res_status_q <= ST_OK;
			res_trig_q   <= 1'b0;
			res_rising_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					rd_idx_q     <= '0;
					cmp_live_q   <= 1'b0;
					hit_q        <= 1'b0;
					free_found_q <= 1'b0;
					if (accept) begin
						res_status_q <= early_status;
						res_trig_q   <= 1'b0;
						res_rising_q <= 1'b0;
						state_q      <= early_done ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					// advance the read address, hold at the last slot
					cmp_idx_q  <= rd_idx_q;
					cmp_live_q <= 1'b1;
					if (rd_idx_q != LAST_IDX) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					// note the lowest free slot
					if (cmp_live_q && !valid_q[cmp_idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= cmp_idx_q;
					end
					if (cmp_hit) begin
						hit_q   <= 1'b1;
						slot_q  <= cmp_idx_q;
						state_q <= S_APPLY;
					end else if (cmp_live_q && cmp_idx_q == LAST_IDX) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (ap_claim) begin
						valid_q[ap_sel] <= 1'b1;
						used_q          <= used_q + 1'b1;
					end
					if (ap_release) begin
						valid_q[ap_sel] <= 1'b0;
						used_q          <= used_q - 1'b1;
					end
					if (ap_primed_we) begin
						primed_q[ap_sel] <= ap_primed_val;
					end
					if (ap_last_we) begin
						last_q[ap_sel] <= ap_last_val;
					end
					res_status_q <= ap_status;
					res_trig_q   <= ap_trig;
					res_rising_q <= ap_rising;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// hand the result over when the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_trig_q   <= res_trig_q;
			out_rising_q <= res_rising_q;
			out_id_q     <= res_trig_q ? 16'(id_q) : 16'd0;
			out_time_q   <= res_trig_q ? now_q : 32'd0;
			if (32'(used_q) > 32'(USED_MAX)) begin
				out_used_q <= USED_W'(USED_MAX);
			end else begin
				out_used_q <= USED_W'(used_q);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign trigger_valid   = out_trig_q;
	assign trigger_rising  = out_rising_q;
	assign trigger_rule_id = out_id_q;
	assign trigger_time_ms = out_time_q;
	assign slots_used      = out_used_q;

endmodule

// ===== sim/tb_per_rule_condition_edge_tracker.sv =====
// Testbench for the per-rule condition edge tracker: directed status, edge and
// release checks, then random rule traffic checked against a slot-table predictor.
// Depends on pcet_pkg and per_rule_condition_edge_tracker.
`timescale 1ns / 1ps

module tb_per_rule_condition_edge_tracker;
	import pcet_pkg::*;

	localparam int SLOTS    = 16;
	localparam int POOL     = 24;
	localparam int HOLD_CYC = 400;

	typedef struct {
		logic        op;
		logic [15:0] rule_id;
		logic        request_ok;
		logic        rule_found;
		logic        rule_valid;
		logic        rule_enabled;
		outcome_t    eval_outcome;
		logic        queue_accepts;
		logic [31:0] now_ms;
	} rule_req_t;

	typedef struct {
		status_t            status;
		logic               trig_valid;
		logic               trig_rising;
		logic [15:0]        trig_id;
		logic [31:0]        trig_time;
		logic [USED_W-1:0]  used;
	} edge_verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic op;
	logic [15:0] rule_id;
	logic request_ok;
	logic rule_found;
	logic rule_valid;
	logic rule_enabled;
	outcome_t eval_outcome;
	logic queue_accepts;
	logic [31:0] now_ms;
	logic out_valid;
	logic out_stall;
	status_t status;
	logic trigger_valid;
	logic trigger_rising;
	logic [15:0] trigger_rule_id;
	logic [31:0] trigger_time_ms;
	logic [USED_W-1:0] slots_used;

	// Slot table mirror
	bit          tbl_valid[SLOTS];
	logic [15:0] tbl_key[SLOTS];
	bit          tbl_primed[SLOTS];
	bit          tbl_last_true[SLOTS];
	logic [31:0] tbl_eval_time[SLOTS];
	logic [31:0] tbl_change_time[SLOTS];

	edge_verdict_t pending_verdicts[$];
	int mismatch_count = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	logic [15:0] id_pool[POOL];
	logic [31:0] clock_ms = 32'd0;

	per_rule_condition_edge_tracker #(
		.SLOTS(SLOTS),
		.ID_BITS(16)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rule_id(rule_id),
		.request_ok(request_ok),
		.rule_found(rule_found),
		.rule_valid(rule_valid),
		.rule_enabled(rule_enabled),
		.eval_outcome(eval_outcome),
		.queue_accepts(queue_accepts),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.trigger_valid(trigger_valid),
		.trigger_rising(trigger_rising),
		.trigger_rule_id(trigger_rule_id),
		.trigger_time_ms(trigger_time_ms),
		.slots_used(slots_used)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drop the per-rule history of one slot
	function automatic void clear_entry(int s);
		tbl_primed[s] = 1'b0;
		tbl_last_true[s] = 1'b0;
		tbl_eval_time[s] = '0;
		tbl_change_time[s] = '0;
	endfunction

	// Apply one transaction to the slot table and return the verdict it yields
	function automatic edge_verdict_t track_rule_edges(rule_req_t r);
		edge_verdict_t v;
		int hit;
		int free;
		int used;
		logic now_true;
		v = '{status: ST_OK, trig_valid: 1'b0, trig_rising: 1'b0, trig_id: '0,
			trig_time: '0, used: '0};
		hit = -1;
		free = -1;
		used = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (r.rule_id != 0 && tbl_valid[i] && tbl_key[i] == r.rule_id && hit < 0)
				hit = i;
			if (!tbl_valid[i] && free < 0)
				free = i;
		end
		if (r.op == OP_RELEASE) begin
			if (hit >= 0) begin
				tbl_valid[hit] = 1'b0;
				clear_entry(hit);
			end
		end else if (r.rule_id == 0) begin
			v.status = ST_BAD_ID;
		end else if (!r.request_ok) begin
			v.status = ST_BAD_REQ;
		end else if (!r.rule_found) begin
			v.status = ST_NOT_FOUND;
		end else if (!r.rule_valid) begin
			v.status = ST_INVALID;
		end else if (!r.rule_enabled) begin
			v.status = ST_DISABLED;
			if (hit >= 0)
				clear_entry(hit);
		end else if (hit < 0 && free < 0) begin
			v.status = ST_FULL;
		end else begin
			// Claim the lowest free slot for a new id
			if (hit < 0) begin
				hit = free;
				tbl_valid[hit] = 1'b1;
				tbl_key[hit] = r.rule_id;
				clear_entry(hit);
			end
			now_true = (r.eval_outcome == OUT_TRUE);
			if (r.eval_outcome > OUT_FALSE) begin
				tbl_eval_time[hit] = r.now_ms;
				v.status = ST_EVAL_FAIL;
			end else if (!tbl_primed[hit]) begin
				tbl_primed[hit] = 1'b1;
				tbl_last_true[hit] = now_true;
				tbl_eval_time[hit] = r.now_ms;
			end else if (tbl_last_true[hit] == now_true) begin
				tbl_eval_time[hit] = r.now_ms;
			end else if (!r.queue_accepts) begin
				v.status = ST_QUEUE_FULL;
			end else begin
				v.trig_valid = 1'b1;
				v.trig_rising = now_true;
				v.trig_id = r.rule_id;
				v.trig_time = r.now_ms;
				tbl_last_true[hit] = now_true;
				tbl_eval_time[hit] = r.now_ms;
				tbl_change_time[hit] = r.now_ms;
			end
		end
		for (int i = 0; i < SLOTS; i++)
			used += int'(tbl_valid[i]);
		v.used = USED_W'((used > USED_MAX) ? USED_MAX : used);
		return v;
	endfunction

	// Build a well-formed evaluation of an enabled, valid rule
	function automatic rule_req_t good_eval(logic [15:0] id, outcome_t oc, logic [31:0] t);
		rule_req_t r;
		r = '{op: OP_EVAL, rule_id: id, request_ok: 1'b1, rule_found: 1'b1,
			rule_valid: 1'b1, rule_enabled: 1'b1, eval_outcome: oc,
			queue_accepts: 1'b1, now_ms: t};
		return r;
	endfunction

	function automatic rule_req_t release_of(logic [15:0] id);
		rule_req_t r;
		r = good_eval(id, OUT_TRUE, clock_ms);
		r.op = OP_RELEASE;
		return r;
	endfunction

	// Mostly well-formed evaluations over a small id pool, some releases and noise
	function automatic rule_req_t rand_request();
		rule_req_t r;
		int pick;
		pick = $urandom_range(99);
		clock_ms += $urandom_range(1, 500);
		r = good_eval(id_pool[$urandom_range(POOL - 1)], OUT_TRUE, clock_ms);
		if (pick < 8) begin
			r.op = OP_RELEASE;
		end else if (pick < 22) begin
			r.op = 1'($urandom_range(1));
			if ($urandom_range(3) != 0)
				r.rule_id = 16'($urandom);
			r.request_ok = 1'($urandom_range(1));
			r.rule_found = 1'($urandom_range(1));
			r.rule_valid = 1'($urandom_range(1));
			r.rule_enabled = 1'($urandom_range(1));
			r.eval_outcome = 2'($urandom_range(3));
			r.queue_accepts = 1'($urandom_range(1));
			r.now_ms = $urandom;
		end else begin
			r.eval_outcome = 2'(($urandom_range(99) < 6) ? $urandom_range(2, 3)
				: $urandom_range(1));
			r.rule_enabled = ($urandom_range(99) >= 4);
			r.queue_accepts = ($urandom_range(99) >= 15);
		end
		return r;
	endfunction

	// Offer one transaction, hold it until accepted, then record its verdict
	task automatic send_request(input rule_req_t r);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 38)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		op <= r.op;
		rule_id <= r.rule_id;
		request_ok <= r.request_ok;
		rule_found <= r.rule_found;
		rule_valid <= r.rule_valid;
		rule_enabled <= r.rule_enabled;
		eval_outcome <= r.eval_outcome;
		queue_accepts <= r.queue_accepts;
		now_ms <= r.now_ms;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_verdicts.push_back(track_rule_edges(r));
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0h got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Each status check in its fixed order, all later flags good
	task automatic test_status_order();
		rule_req_t r;
		send_request(good_eval(16'h0000, OUT_TRUE, 32'd10));
		r = good_eval(16'h1234, OUT_TRUE, 32'd11);
		r.request_ok = 1'b0;
		send_request(r);
		r = good_eval(16'h1234, OUT_TRUE, 32'd12);
		r.rule_found = 1'b0;
		send_request(r);
		r = good_eval(16'h1234, OUT_TRUE, 32'd13);
		r.rule_valid = 1'b0;
		send_request(r);
		r = good_eval(16'h1234, OUT_TRUE, 32'd14);
		r.rule_enabled = 1'b0;
		send_request(r);
	endtask

	// Prime, hold, refused edge, both edges, evaluator errors and disable on the top id
	task automatic test_edge_sequence();
		rule_req_t r;
		send_request(good_eval(16'hFFFF, OUT_TRUE, 32'h0000_0000));
		send_request(good_eval(16'hFFFF, OUT_TRUE, 32'h0000_0001));
		r = good_eval(16'hFFFF, OUT_FALSE, 32'h0000_0002);
		r.queue_accepts = 1'b0;
		send_request(r);
		send_request(good_eval(16'hFFFF, OUT_FALSE, 32'hFFFF_FFFF));
		send_request(good_eval(16'hFFFF, OUT_TRUE, 32'h8000_0000));
		send_request(good_eval(16'hFFFF, 2'd2, 32'h0000_0003));
		send_request(good_eval(16'hFFFF, 2'd3, 32'h0000_0004));
		r = good_eval(16'hFFFF, OUT_TRUE, 32'h0000_0005);
		r.rule_enabled = 1'b0;
		send_request(r);
		send_request(good_eval(16'hFFFF, OUT_FALSE, 32'h0000_0006));
	endtask

	// Release a held id, an unknown id and id zero, then reclaim through an error outcome
	task automatic test_release_cases();
		send_request(release_of(16'hFFFF));
		send_request(release_of(16'hFFFF));
		send_request(release_of(16'h0000));
		send_request(good_eval(16'h0001, 2'd3, 32'd100));
		send_request(good_eval(16'h0001, OUT_TRUE, 32'd101));
		send_request(good_eval(16'h0001, OUT_FALSE, 32'd102));
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < POOL; i++)
			id_pool[i] = 16'($urandom_range(1, 65535));
		repeat (850) send_request(rand_request());
	endtask

	// Hold the result side off while the sender keeps offering
	task automatic test_input_backpressure();
		steady = 1'b1;
		hold_req = 1'b1;
		repeat (40) send_request(rand_request());
		steady = 1'b0;
	endtask

	task automatic test_steady_burst();
		steady = 1'b1;
		repeat (80) send_request(rand_request());
		steady = 1'b0;
	endtask

	// Result side: random stalls, plus a long counted hold when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYC;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < 38);
			end
		end
	end

	// Compare each accepted result with the oldest predicted verdict
	initial begin
		edge_verdict_t want;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_verdicts.size() == 0) begin
					$error("result transaction with no evaluation pending");
					mismatch_count++;
				end else begin
					want = pending_verdicts.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("trigger_valid", 32'(want.trig_valid), 32'(trigger_valid));
					check_field("trigger_rising", 32'(want.trig_rising),
						32'(trigger_rising));
					check_field("trigger_rule_id", 32'(want.trig_id), 32'(trigger_rule_id));
					check_field("trigger_time_ms", want.trig_time, trigger_time_ms);
					check_field("slots_used", 32'(want.used), 32'(slots_used));
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_EVAL;
		rule_id = '0;
		request_ok = 1'b0;
		rule_found = 1'b0;
		rule_valid = 1'b0;
		rule_enabled = 1'b0;
		eval_outcome = OUT_TRUE;
		queue_accepts = 1'b0;
		now_ms = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_status_order();
		test_edge_sequence();
		test_release_cases();
		test_random_traffic();
		test_input_backpressure();
		test_steady_burst();

		// Drain outstanding results, then report the outcome
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
